>>> src/least_squares_trend_detector_macros.svh
// Assertion helpers for the least-squares trend detector.
// All checks are sampled on clk and are off while rst_n is low.
`ifndef LEAST_SQUARES_TREND_DETECTOR_MACROS_SVH
`define LEAST_SQUARES_TREND_DETECTOR_MACROS_SVH

// Same-cycle implication
`define LSTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LSTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lstd_pkg.sv
// ----------------------------------------------------------------------------
// lstd_pkg
// Field widths, register map and saturation limits of the trend detector.
// ----------------------------------------------------------------------------
package lstd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SLOPE_W    = 32;
    localparam int ICPT_W     = 24;
    localparam int THR_W      = 31;
    localparam int FRAC_SHIFT = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_TREND_THRESHOLD = 1'b0;

    localparam logic [THR_W-1:0] THR_RESET = 31'd33554;

    localparam logic [SLOPE_W-1:0] SLOPE_MAX = 32'h7FFF_FFFF;
    localparam logic [SLOPE_W-1:0] SLOPE_MIN = 32'h8000_0000;
    localparam logic [ICPT_W-1:0]  ICPT_MAX  = 24'h7F_FFFF;
    localparam logic [ICPT_W-1:0]  ICPT_MIN  = 24'h80_0000;

endpackage

>>> src/least_squares_trend_detector.sv
// ----------------------------------------------------------------------------
// least_squares_trend_detector
// Ordinary least-squares line fit over a sample series with trend flag.
// ----------------------------------------------------------------------------
// Samples are taken while busy is low; each one keeps busy high while one
// shared shift-add multiplier folds index*index and index*sample into the
// running sums. The sample that closes a series then runs six products
// through the same multiplier and two restoring divisions through the same
// adder, then presents the fit on done for one cycle; the result registers
// are overwritten by the next series' fit, so capture it on that cycle.
// A one-sample series skips the numerator products and the divisions and
// reports fit_valid low with zero fields.
`include "least_squares_trend_detector_macros.svh"

module least_squares_trend_detector
    import lstd_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // sample channel
    input  logic                         start,
    output logic                         busy,
    input  logic signed [SAMPLE_W-1:0]   sample,
    input  logic                         last,
    // result channel
    output logic                         done,
    output logic signed [SLOPE_W-1:0]    slope,
    output logic signed [ICPT_W-1:0]     intercept,
    output logic                         has_trend,
    output logic                         fit_valid,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [CFG_DATA_W-1:0]        pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SXW   = 2 * CW;
    localparam int SXXW  = 3 * CW;
    localparam int SYW   = SAMPLE_W + CW;
    localparam int SXYW  = SAMPLE_W + 2 * CW;
    localparam int DW    = 4 * CW;
    localparam int NW_A  = 3 * CW + SAMPLE_W + FRAC_SHIFT + 2;
    localparam int NW_B  = 4 * CW + SAMPLE_W + 2;
    localparam int NW    = (NW_A > NW_B) ? NW_A : NW_B;
    localparam int MBW   = (SXW > SYW) ? SXW : SYW;
    localparam int DCW   = $clog2(NW + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DLOAD = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [2:0] OP_XX  = 3'd0;
    localparam logic [2:0] OP_XY  = 3'd1;
    localparam logic [2:0] OP_DN0 = 3'd2;
    localparam logic [2:0] OP_DN1 = 3'd3;
    localparam logic [2:0] OP_NA0 = 3'd4;
    localparam logic [2:0] OP_NA1 = 3'd5;
    localparam logic [2:0] OP_NB0 = 3'd6;
    localparam logic [2:0] OP_NB1 = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [2:0]                  op_reg, op_next;
    logic signed [SAMPLE_W-1:0]  y_reg, y_next;
    logic                        last_reg, last_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [SXW-1:0]              sx_reg, sx_next;
    logic [SXXW-1:0]             sxx_reg, sxx_next;
    logic signed [SYW-1:0]       sy_reg, sy_next;
    logic signed [SXYW-1:0]      sxy_reg, sxy_next;
    logic [NW-1:0]               mac_reg, mac_next;
    logic [NW-1:0]               mcand_reg, mcand_next;
    logic [MBW-1:0]              mplier_reg, mplier_next;
    logic                        neg_reg, neg_next;
    logic [DW-1:0]               den_reg, den_next;
    logic [NW-1:0]               num_reg, num_next;
    logic [NW-1:0]               dq_reg, dq_next;
    logic [DW-1:0]               rem_reg, rem_next;
    logic                        qneg_reg, qneg_next;
    logic [DCW-1:0]              dcnt_reg, dcnt_next;
    logic                        dsel_reg, dsel_next;
    logic [SLOPE_W-1:0]          slope_reg, slope_next;
    logic [ICPT_W-1:0]           icpt_reg, icpt_next;
    logic                        trend_reg, trend_next;
    logic                        valid_reg, valid_next;
    logic [THR_W-1:0]            thr_reg, thr_next;

    // shared adder
    logic [NW-1:0]    alu_a, alu_b, alu_sum;
    logic             alu_sub;

    // operand select for the multiplier
    logic [NW-1:0]    ld_init, ld_a;
    logic [MBW-1:0]   ld_b;
    logic             ld_neg, ld_keep;

    logic [SAMPLE_W-1:0] y_mag;
    logic [SYW-1:0]      sy_mag;
    logic [SXYW-1:0]     sxy_mag;
    logic [CW-1:0]       count_inc;
    logic                series_end;
    logic [DW:0]         rem_sh;
    logic                qbit;
    logic [NW-1:0]       div_src;
    logic                slope_ovf, icpt_ovf;
    logic [SLOPE_W-1:0]  slope_sat, slope_mag;
    logic [ICPT_W-1:0]   icpt_sat;
    logic                cfg_wr;

    assign y_mag   = y_reg[SAMPLE_W-1] ? SAMPLE_W'(-y_reg) : SAMPLE_W'(y_reg);
    assign sy_mag  = sy_reg[SYW-1] ? SYW'(-sy_reg) : SYW'(sy_reg);
    assign sxy_mag = sxy_reg[SXYW-1] ? SXYW'(-sxy_reg) : SXYW'(sxy_reg);

    assign count_inc  = count_reg + 1'b1;
    assign series_end = last_reg || (count_inc == CW'(MAX_SAMPLES));

    assign rem_sh = {rem_reg, dq_reg[NW-1]};

    always_comb
    begin
        if (state_reg == ST_DIV)
        begin
            alu_a   = {{(NW-DW-1){1'b0}}, rem_sh};
            alu_b   = {{(NW-DW){1'b0}}, den_reg};
            alu_sub = 1'b1;
        end
        else
        begin
            alu_a   = mac_reg;
            alu_b   = mcand_reg;
            alu_sub = neg_reg;
        end
    end

    assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign qbit    = ~alu_sum[NW-1];

    always_comb
    begin
        ld_init = '0;
        ld_a    = '0;
        ld_b    = '0;
        ld_neg  = 1'b0;
        ld_keep = 1'b0;
        case (op_reg)
            OP_XX:
            begin
                ld_init = {{(NW-SXXW){1'b0}}, sxx_reg};
                ld_a    = {{(NW-CW){1'b0}}, count_reg};
                ld_b    = {{(MBW-CW){1'b0}}, count_reg};
            end
            OP_XY:
            begin
                ld_init = {{(NW-SXYW){sxy_reg[SXYW-1]}}, sxy_reg};
                ld_a    = {{(NW-SAMPLE_W){1'b0}}, y_mag};
                ld_b    = {{(MBW-CW){1'b0}}, count_reg};
                ld_neg  = y_reg[SAMPLE_W-1];
            end
            OP_DN0:
            begin
                ld_a    = {{(NW-SXXW){1'b0}}, sxx_reg};
                ld_b    = {{(MBW-CW){1'b0}}, count_reg};
            end
            OP_DN1:
            begin
                ld_keep = 1'b1;
                ld_a    = {{(NW-SXW){1'b0}}, sx_reg};
                ld_b    = {{(MBW-SXW){1'b0}}, sx_reg};
                ld_neg  = 1'b1;
            end
            OP_NA0:
            begin
                ld_a    = {{(NW-SXYW){1'b0}}, sxy_mag};
                ld_b    = {{(MBW-CW){1'b0}}, count_reg};
                ld_neg  = sxy_reg[SXYW-1];
            end
            OP_NA1:
            begin
                ld_keep = 1'b1;
                ld_a    = {{(NW-SXW){1'b0}}, sx_reg};
                ld_b    = {{(MBW-SYW){1'b0}}, sy_mag};
                ld_neg  = ~sy_reg[SYW-1];
            end
            OP_NB0:
            begin
                ld_a    = {{(NW-SXXW){1'b0}}, sxx_reg};
                ld_b    = {{(MBW-SYW){1'b0}}, sy_mag};
                ld_neg  = sy_reg[SYW-1];
            end
            OP_NB1:
            begin
                ld_keep = 1'b1;
                ld_a    = {{(NW-SXYW){1'b0}}, sxy_mag};
                ld_b    = {{(MBW-SXW){1'b0}}, sx_reg};
                ld_neg  = ~sxy_reg[SXYW-1];
            end
            default:
            begin
                ld_keep = 1'b1;
            end
        endcase
    end

    // slope numerator carries the Q.16 scale before division
    assign div_src = dsel_reg ? mac_reg : {num_reg[NW-FRAC_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};

    assign slope_ovf = |dq_reg[NW-1:SLOPE_W-1];
    assign icpt_ovf  = |dq_reg[NW-1:ICPT_W-1];

    always_comb
    begin
        if (slope_ovf)
        begin
            slope_sat = qneg_reg ? SLOPE_MIN : SLOPE_MAX;
            slope_mag = qneg_reg ? SLOPE_MIN : SLOPE_MAX;
        end
        else
        begin
            slope_sat = qneg_reg ? SLOPE_W'(-dq_reg[SLOPE_W-1:0]) : dq_reg[SLOPE_W-1:0];
            slope_mag = dq_reg[SLOPE_W-1:0];
        end
        if (icpt_ovf)
            icpt_sat = qneg_reg ? ICPT_MIN : ICPT_MAX;
        else
            icpt_sat = qneg_reg ? ICPT_W'(-dq_reg[ICPT_W-1:0]) : dq_reg[ICPT_W-1:0];
    end

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TREND_THRESHOLD);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        y_next      = y_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        sx_next     = sx_reg;
        sxx_next    = sxx_reg;
        sy_next     = sy_reg;
        sxy_next    = sxy_reg;
        mac_next    = mac_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        neg_next    = neg_reg;
        den_next    = den_reg;
        num_next    = num_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        qneg_next   = qneg_reg;
        dcnt_next   = dcnt_reg;
        dsel_next   = dsel_reg;
        slope_next  = slope_reg;
        icpt_next   = icpt_reg;
        trend_next  = trend_reg;
        valid_next  = valid_reg;
        thr_next    = cfg_wr ? pwdata[THR_W-1:0] : thr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    y_next     = sample;
                    last_next  = last;
                    op_next    = OP_XX;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                mac_next    = ld_keep ? mac_reg : ld_init;
                mcand_next  = ld_a;
                mplier_next = ld_b;
                neg_next    = ld_neg;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                if (mplier_reg != '0)
                begin
                    if (mplier_reg[0])
                        mac_next = alu_sum;
                    mcand_next  = {mcand_reg[NW-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[MBW-1:1]};
                end
                else
                begin
                    op_next    = op_reg + 1'b1;
                    state_next = ST_LOAD;
                    case (op_reg)
                        OP_XX:
                        begin
                            sxx_next = mac_reg[SXXW-1:0];
                        end
                        OP_XY:
                        begin
                            sxy_next   = mac_reg[SXYW-1:0];
                            sx_next    = sx_reg + {{(SXW-CW){1'b0}}, count_reg};
                            sy_next    = sy_reg + {{(SYW-SAMPLE_W){y_reg[SAMPLE_W-1]}}, y_reg};
                            count_next = count_inc;
                            if (!series_end)
                                state_next = ST_IDLE;
                        end
                        OP_DN1:
                        begin
                            den_next = mac_reg[DW-1:0];
                            // one sample: no line through a single point
                            if (mac_reg == '0)
                            begin
                                slope_next = '0;
                                icpt_next  = '0;
                                trend_next = 1'b0;
                                valid_next = 1'b0;
                                state_next = ST_OUT;
                            end
                        end
                        OP_NA1:
                        begin
                            num_next = mac_reg;
                        end
                        OP_NB1:
                        begin
                            dsel_next  = 1'b0;
                            state_next = ST_DLOAD;
                        end
                        default:
                        begin
                            state_next = ST_LOAD;
                        end
                    endcase
                end
            end
            ST_DLOAD:
            begin
                qneg_next  = div_src[NW-1];
                dq_next    = div_src[NW-1] ? NW'(-div_src) : div_src;
                rem_next   = '0;
                dcnt_next  = DCW'(NW);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (dcnt_reg != '0)
                begin
                    rem_next  = qbit ? alu_sum[DW-1:0] : rem_sh[DW-1:0];
                    dq_next   = {dq_reg[NW-2:0], qbit};
                    dcnt_next = dcnt_reg - 1'b1;
                end
                else if (!dsel_reg)
                begin
                    slope_next = slope_sat;
                    trend_next = slope_mag > {1'b0, thr_reg};
                    dsel_next  = 1'b1;
                    state_next = ST_DLOAD;
                end
                else
                begin
                    icpt_next  = icpt_sat;
                    valid_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // start the next series from index zero
                count_next = '0;
                sx_next    = '0;
                sxx_next   = '0;
                sy_next    = '0;
                sxy_next   = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_XX;
            count_reg <= '0;
            sx_reg    <= '0;
            sxx_reg   <= '0;
            sy_reg    <= '0;
            sxy_reg   <= '0;
            dcnt_reg  <= '0;
            dsel_reg  <= 1'b0;
            thr_reg   <= THR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            count_reg <= count_next;
            sx_reg    <= sx_next;
            sxx_reg   <= sxx_next;
            sy_reg    <= sy_next;
            sxy_reg   <= sxy_next;
            dcnt_reg  <= dcnt_next;
            dsel_reg  <= dsel_next;
            thr_reg   <= thr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg      <= y_next;
        last_reg   <= last_next;
        mac_reg    <= mac_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        neg_reg    <= neg_next;
        den_reg    <= den_next;
        num_reg    <= num_next;
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        qneg_reg   <= qneg_next;
        slope_reg  <= slope_next;
        icpt_reg   <= icpt_next;
        trend_reg  <= trend_next;
        valid_reg  <= valid_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_OUT);
    assign slope     = slope_reg;
    assign intercept = icpt_reg;
    assign has_trend = trend_reg;
    assign fit_valid = valid_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TREND_THRESHOLD) ? {1'b0, thr_reg} : '0;

    `LSTD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted sample did not raise busy")
    `LSTD_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "result strobe longer than one cycle")
    `LSTD_ASSERT_NOW(a_invalid_zero, done && !fit_valid, slope == '0 && intercept == '0 && !has_trend, "invalid fit carries nonzero fields")
    `LSTD_ASSERT_NOW(a_div_den, state_reg == ST_DIV, den_reg != '0, "division started with zero denominator")
    `LSTD_ASSERT_NOW(a_out_cleared, done, count_reg != '0, "series closed with no samples")

endmodule
